### rtl/deqsum_pkg.sv
package deqsum_pkg;

    // element width and default queue depth
    localparam int DATA_W           = 32;
    localparam int DEFAULT_CAPACITY = 1024;

    // queue operations
    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } opcode_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // per-cycle control broadcast to every cell of a chain
    typedef struct packed {
        logic shift_right;  // take left neighbor, insert at cell 0
        logic shift_left;   // take right neighbor, drop cell 0
        logic write_en;     // write the cell whose index matches
    } chain_ctrl_t;

endpackage

### rtl/deqsum_cell.sv
module deqsum_cell
    import deqsum_pkg::*;
#(
    parameter int CNT_W = 11,
    parameter int INDEX = 0
)
(
    input  logic              clk,
    input  chain_ctrl_t       ctrl,
    input  logic [CNT_W-1:0]  wr_idx,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    output logic [DATA_W-1:0] data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // shift wins over indexed write; only one is ever requested at a time
    always_comb
    begin
        data_next = data_reg;
        priority if (ctrl.shift_right)
        begin
            data_next = left_data;
        end
        else if (ctrl.shift_left)
        begin
            data_next = right_data;
        end
        else if (ctrl.write_en && (wr_idx == CNT_W'(INDEX)))
        begin
            data_next = wr_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### rtl/deqsum_chain.sv
module deqsum_chain
    import deqsum_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
)
(
    input  logic              clk,
    input  chain_ctrl_t       ctrl,
    input  logic [CNT_W-1:0]  wr_idx,
    input  logic [DATA_W-1:0] wr_data,
    output logic [DATA_W-1:0] head_data
);

    logic [DATA_W-1:0] cell_data [CAPACITY];

    // row of cells, each handing its entry to a neighbor on a shift
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_in;
        logic [DATA_W-1:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = wr_data;
        end
        else
        begin : g_mid_left
            assign left_in = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_mid_right
            assign right_in = cell_data[i+1];
        end

        deqsum_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .wr_idx     (wr_idx),
            .wr_data    (wr_data),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[i])
        );
    end

    assign head_data = cell_data[0];

endmodule

### rtl/double_ended_queue_with_sum_unit.sv
// result: registered, valid in the cycle after its input transaction is accepted
// throughput: one operation per cycle unless out_ready stalls a pending result; set by the
// neighbor shift of the two cell chains and the 32-bit add/subtract of the running sum
// reset: element count, running sum and output valid clear asynchronously;
// cell contents are not reset and are only read after being pushed
module double_ended_queue_with_sum_unit
    import deqsum_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               opcode,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               status,
    output logic [CNT_W-1:0]         element_count,
    output logic signed [DATA_W-1:0] element_sum
);

    // chain a holds elements front first, chain b holds them back first
    chain_ctrl_t       ctrl_a;
    chain_ctrl_t       ctrl_b;
    logic [DATA_W-1:0] front_data;
    logic [DATA_W-1:0] back_data;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [DATA_W-1:0] sum_reg;
    logic [DATA_W-1:0] sum_next;
    status_t           status_next;

    logic              out_valid_reg;
    status_t           status_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic [DATA_W-1:0] out_sum_reg;

    logic    in_fire;
    logic    is_full;
    logic    is_empty;
    opcode_t op;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign op       = opcode_t'(opcode);
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // operation decode and next count and sum
    always_comb
    begin
        ctrl_a      = '0;
        ctrl_b      = '0;
        count_next  = count_reg;
        sum_next    = sum_reg;
        status_next = ST_DONE;
        unique case (op)
            OP_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctrl_a.shift_right = in_fire;
                    ctrl_b.write_en    = in_fire;
                    count_next         = count_reg + 1'b1;
                    sum_next           = sum_reg + value;
                end
            end
            OP_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctrl_b.shift_right = in_fire;
                    ctrl_a.write_en    = in_fire;
                    count_next         = count_reg + 1'b1;
                    sum_next           = sum_reg + value;
                end
            end
            OP_POP_FRONT:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    ctrl_a.shift_left = in_fire;
                    count_next        = count_reg - 1'b1;
                    sum_next          = sum_reg - front_data;
                end
            end
            OP_POP_BACK:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    ctrl_b.shift_left = in_fire;
                    count_next        = count_reg - 1'b1;
                    sum_next          = sum_reg - back_data;
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    // front-first chain
    deqsum_chain #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_chain_a (
        .clk       (clk),
        .ctrl      (ctrl_a),
        .wr_idx    (count_reg),
        .wr_data   (value),
        .head_data (front_data)
    );

    // back-first chain
    deqsum_chain #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_chain_b (
        .clk       (clk),
        .ctrl      (ctrl_b),
        .wr_idx    (count_reg),
        .wr_data   (value),
        .head_data (back_data)
    );

    // queue state and valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                count_reg     <= count_next;
                sum_reg       <= sum_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            status_reg    <= status_next;
            out_count_reg <= count_next;
            out_sum_reg   <= sum_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign element_count = out_count_reg;
    assign element_sum   = out_sum_reg;

`ifndef NO_ASSERTIONS
    // count never exceeds the queue capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    // a full result reports a full queue
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == ST_FULL)) |-> (out_count_reg == CNT_W'(CAPACITY)))
        else $error("full status with count below capacity");

    // an empty result reports zero count and zero sum
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == ST_EMPTY)) |-> ((out_count_reg == '0)
            && (out_sum_reg == '0)))
        else $error("empty status with nonzero count or sum");

    // an accepted push into a non-full queue grows the count by one
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !is_full && ((op == OP_PUSH_FRONT) || (op == OP_PUSH_BACK)))
            |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push did not grow the count");
`endif

endmodule
